// ===== src/label_grid_majority_filter_top_macros.svh =====
`ifndef LABEL_GRID_MAJORITY_FILTER_TOP_MACROS_SVH
`define LABEL_GRID_MAJORITY_FILTER_TOP_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define LGMF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds while reset is asserted.
`define LGMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lgmf_pkg.sv =====
`timescale 1ns / 1ps

package lgmf_pkg;

    localparam int unsigned LABEL_W     = 3;
    localparam int unsigned COL_W       = 11;
    localparam int unsigned ROW_W       = 16;
    localparam int unsigned NUM_CLASSES = 6;
    localparam int unsigned CNT_W       = 4;

    // Class that out-of-range codes are counted as.
    localparam logic [LABEL_W-1:0] FALLBACK_CLASS = 3'd1;

    typedef enum logic {
        REG_COLS = 1'b0,
        REG_ROWS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               flush;
    } t_in;

    typedef struct packed {
        logic [LABEL_W-1:0] smoothed;
        logic               frame_end;
    } t_out;

    // Per-item control worked out when the item is taken in.
    typedef struct packed {
        logic emit;
        logic frame_end;
        logic use_left;
        logic use_right;
        logic use_top;
        logic use_bottom;
    } t_item_ctl;

    function automatic logic [LABEL_W-1:0] class_of(input logic [LABEL_W-1:0] v);
        return ((CNT_W)'(v) < (CNT_W)'(NUM_CLASSES)) ? v : FALLBACK_CLASS;
    endfunction

endpackage

// ===== src/lgmf_line_mem.sv =====
`timescale 1ns / 1ps

module lgmf_line_mem #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [ADDR_W-1:0]            i_rd_addr,
    output logic [lgmf_pkg::LABEL_W-1:0] o_rd_data,
    input  logic                         i_wr_en,
    input  logic [ADDR_W-1:0]            i_wr_addr,
    input  logic [lgmf_pkg::LABEL_W-1:0] i_wr_data
);

    logic [lgmf_pkg::LABEL_W-1:0] mem [DEPTH];
    logic [lgmf_pkg::LABEL_W-1:0] r_rd_data;

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/lgmf_pos.sv =====
`timescale 1ns / 1ps

module lgmf_pos #(
    parameter int unsigned MAX_COLS = 1024,
    parameter int unsigned ADDR_W   = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_acc,
    input  logic [lgmf_pkg::COL_W-1:0] i_cols,
    input  logic [lgmf_pkg::ROW_W-1:0] i_rows,
    output logic [ADDR_W-1:0]          o_addr,
    output lgmf_pkg::t_item_ctl        o_ctl
);

    localparam int unsigned XW = ((ADDR_W > lgmf_pkg::COL_W) ? ADDR_W : lgmf_pkg::COL_W) + 1;
    localparam int unsigned RW = lgmf_pkg::ROW_W + 1;

    logic [lgmf_pkg::COL_W-1:0] r_in_col,  n_in_col;
    logic [lgmf_pkg::ROW_W-1:0] r_in_row,  n_in_row;
    logic [lgmf_pkg::COL_W-1:0] r_out_col, n_out_col;
    logic [lgmf_pkg::ROW_W-1:0] r_out_row, n_out_row;

    logic [XW-1:0]              cols_x;
    logic [XW-1:0]              nc;
    logic [lgmf_pkg::ROW_W-1:0] nr;
    logic [XW-1:0]              in_col_x;
    logic                       in_wrap;
    logic                       out_wrap;
    logic                       out_last_row;

    always_comb begin
        cols_x = XW'(i_cols);
        if (i_cols == '0) begin
            nc = XW'(1);
        end else if (cols_x > XW'(MAX_COLS)) begin
            nc = XW'(MAX_COLS);
        end else begin
            nc = cols_x;
        end
        nr = (i_rows == '0) ? lgmf_pkg::ROW_W'(1) : i_rows;
    end

    assign in_col_x     = XW'(r_in_col);
    assign in_wrap      = (in_col_x + XW'(1)) >= nc;
    assign out_wrap     = (XW'(r_out_col) + XW'(1)) >= nc;
    assign out_last_row = (RW'(r_out_row) + RW'(1)) >= RW'(nr);

    assign o_addr = (in_col_x < XW'(MAX_COLS)) ? in_col_x[ADDR_W-1:0] : '0;

    always_comb begin
        o_ctl.emit       = (r_in_row >= lgmf_pkg::ROW_W'(2))
                        || ((r_in_row == lgmf_pkg::ROW_W'(1)) && (r_in_col != '0));
        o_ctl.frame_end  = out_last_row && out_wrap;
        o_ctl.use_left   = (r_out_col != '0);
        o_ctl.use_right  = !out_wrap;
        o_ctl.use_top    = (r_out_row != '0);
        o_ctl.use_bottom = !out_last_row;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_acc) begin
            if (in_wrap) begin
                n_in_col = '0;
                if (r_in_row != '1) begin
                    n_in_row = r_in_row + 1'b1;
                end
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
            if (o_ctl.emit) begin
                if (o_ctl.frame_end) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_wrap) begin
                    n_out_col = '0;
                    if (r_out_row != '1) begin
                        n_out_row = r_out_row + 1'b1;
                    end
                end else begin
                    n_out_col = r_out_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

endmodule

// ===== src/lgmf_vote.sv =====
`timescale 1ns / 1ps

module lgmf_vote (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic [lgmf_pkg::LABEL_W-1:0] i_top,
    input  logic [lgmf_pkg::LABEL_W-1:0] i_mid,
    input  logic [lgmf_pkg::LABEL_W-1:0] i_lab,
    input  lgmf_pkg::t_item_ctl          i_ctl,
    output logic [lgmf_pkg::LABEL_W-1:0] o_smoothed
);

    // Window indexed [column][row]; column 2 is the newest, row 0 the oldest.
    logic [lgmf_pkg::LABEL_W-1:0] r_win [3][3];
    logic [lgmf_pkg::LABEL_W-1:0] n_win [3][3];

    logic [2:0]                   col_use;
    logic [2:0]                   row_use;
    logic [lgmf_pkg::CNT_W-1:0]   cnt [lgmf_pkg::NUM_CLASSES];
    logic [lgmf_pkg::CNT_W-1:0]   best_n;
    logic [lgmf_pkg::LABEL_W-1:0] best;
    logic [lgmf_pkg::LABEL_W-1:0] cls;

    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2][0] = i_top;
        n_win[2][1] = i_mid;
        n_win[2][2] = i_lab;
    end

    assign col_use = {i_ctl.use_right, 1'b1, i_ctl.use_left};
    assign row_use = {i_ctl.use_bottom, 1'b1, i_ctl.use_top};

    always_comb begin
        for (int k = 0; k < lgmf_pkg::NUM_CLASSES; k++) begin
            cnt[k] = '0;
        end
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                cls = lgmf_pkg::class_of(n_win[c][r]);
                for (int k = 0; k < lgmf_pkg::NUM_CLASSES; k++) begin
                    if (col_use[c] && row_use[r]
                        && (lgmf_pkg::CNT_W'(cls) == lgmf_pkg::CNT_W'(k))) begin
                        cnt[k] = cnt[k] + 1'b1;
                    end
                end
            end
        end
        // Strict compare keeps the lowest class on a tie.
        best   = '0;
        best_n = '0;
        for (int k = 0; k < lgmf_pkg::NUM_CLASSES; k++) begin
            if (cnt[k] > best_n) begin
                best_n = cnt[k];
                best   = lgmf_pkg::LABEL_W'(k);
            end
        end
    end

    assign o_smoothed = best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[c][r] <= '0;
                end
            end
        end else if (i_shift) begin
            r_win <= n_win;
        end
    end

endmodule

// ===== src/label_grid_majority_filter_top.sv =====
`timescale 1ns / 1ps

// 3x3 majority filter over a raster stream of class labels. One item (one grid
// cell, or a flush item after the frame) is taken every clock cycle while the
// output side keeps up; the rate is set by one read and one write per cycle on
// each of the two line stores, which are synchronous memories.
// The result for a cell leaves with the item that arrives cols+1 items later.
// That item's acceptance edge also registers its line store reads, and the
// result is loaded into the output register when the second stage moves on;
// it is offered from there until it is taken. After the last cell of a frame
// send cols+1 flush items to drain the remaining results; the result of the
// last cell carries frame_end and rewinds the block to the first cell of a
// new frame. The line stores need no clearing after reset: an entry is always
// written before a result can depend on it. Program cols and rows while no
// item is in flight.

module label_grid_majority_filter_top #(
    parameter int unsigned MAX_COLS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input items
    input  logic              i_valid,
    output logic              o_stall,
    input  lgmf_pkg::t_in     i_data,
    // result items
    output logic              o_valid,
    input  logic              i_stall,
    output lgmf_pkg::t_out    o_data,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int unsigned ADDR_W = $clog2(MAX_COLS);

    // Configuration registers.
    logic [lgmf_pkg::COL_W-1:0] r_cols;
    logic [lgmf_pkg::ROW_W-1:0] r_rows;
    lgmf_pkg::t_reg_idx         reg_idx;
    logic                       cfg_wr;

    // Front stage: position counters and line store read address.
    logic                         in_acc;
    logic [ADDR_W-1:0]            s0_addr;
    lgmf_pkg::t_item_ctl          s0_ctl;
    logic [lgmf_pkg::LABEL_W-1:0] s0_lab;

    // Second stage: line store data arrives, window shifts, vote is taken.
    logic                         r_s1_vld;
    lgmf_pkg::t_item_ctl          r_s1_ctl;
    logic [ADDR_W-1:0]            r_s1_addr;
    logic [lgmf_pkg::LABEL_W-1:0] r_s1_lab;
    logic                         s1_fire;
    logic [lgmf_pkg::LABEL_W-1:0] above_rd;
    logic [lgmf_pkg::LABEL_W-1:0] cur_rd;
    logic [lgmf_pkg::LABEL_W-1:0] s1_top;
    logic [lgmf_pkg::LABEL_W-1:0] s1_mid;
    logic [lgmf_pkg::LABEL_W-1:0] s1_smoothed;

    // Bypass for a read of the entry that is written in the same cycle.
    logic                         r_fwd_vld;
    logic [lgmf_pkg::LABEL_W-1:0] r_fwd_top;
    logic [lgmf_pkg::LABEL_W-1:0] r_fwd_mid;

    // Output register.
    logic                         r_out_vld;
    lgmf_pkg::t_out               r_out;

    //--------------------------------------------------------------------
    // Register port. Writes land on the access phase; pready is tied high.
    //--------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = lgmf_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= lgmf_pkg::COL_W'(64);
            r_rows <= lgmf_pkg::ROW_W'(64);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                lgmf_pkg::REG_COLS: begin
                    r_cols <= pwdata[lgmf_pkg::COL_W-1:0];
                end
                lgmf_pkg::REG_ROWS: begin
                    r_rows <= pwdata[lgmf_pkg::ROW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lgmf_pkg::REG_COLS: prdata = 32'(r_cols);
            lgmf_pkg::REG_ROWS: prdata = 32'(r_rows);
            default:            prdata = '0;
        endcase
    end

    //--------------------------------------------------------------------
    // Handshake. The second stage always moves on unless it holds a result
    // and the output register is full and stalled. A new item is taken
    // whenever the second stage is empty or moves on in the same cycle.
    //--------------------------------------------------------------------
    assign s1_fire = r_s1_vld && (!r_s1_ctl.emit || !r_out_vld || !i_stall);
    assign o_stall = r_s1_vld && !s1_fire;
    assign in_acc  = i_valid && !o_stall;

    // A flush item counts as class 0 wherever it still lands inside the grid.
    assign s0_lab = i_data.flush ? '0 : i_data.label;

    lgmf_pos #(
        .MAX_COLS (MAX_COLS),
        .ADDR_W   (ADDR_W)
    ) u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_cols  (r_cols),
        .i_rows  (r_rows),
        .o_addr  (s0_addr),
        .o_ctl   (s0_ctl)
    );

    //--------------------------------------------------------------------
    // Line stores. The row-above store receives what the current-row store
    // held, and the current-row store receives the new label, both at the
    // address that was read when the item came in.
    //--------------------------------------------------------------------
    lgmf_line_mem #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (ADDR_W)
    ) u_above (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (s0_addr),
        .o_rd_data (above_rd),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (s1_mid)
    );

    lgmf_line_mem #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (ADDR_W)
    ) u_current (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (s0_addr),
        .o_rd_data (cur_rd),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (r_s1_lab)
    );

    // With a single column every item hits the same entry; the write of the
    // previous item then coincides with this item's read and is bypassed.
    assign s1_top = r_fwd_vld ? r_fwd_top : above_rd;
    assign s1_mid = r_fwd_vld ? r_fwd_mid : cur_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld  <= 1'b1;
                r_fwd_vld <= s1_fire && (r_s1_addr == s0_addr);
            end else if (s1_fire) begin
                r_s1_vld  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ctl  <= s0_ctl;
            r_s1_addr <= s0_addr;
            r_s1_lab  <= s0_lab;
            r_fwd_top <= s1_mid;
            r_fwd_mid <= r_s1_lab;
        end
    end

    lgmf_vote u_vote (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_shift    (s1_fire),
        .i_top      (s1_top),
        .i_mid      (s1_mid),
        .i_lab      (r_s1_lab),
        .i_ctl      (r_s1_ctl),
        .o_smoothed (s1_smoothed)
    );

    //--------------------------------------------------------------------
    // Output register: holds one result item until it is taken.
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire && r_s1_ctl.emit) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && !i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_ctl.emit) begin
            r_out.smoothed  <= s1_smoothed;
            r_out.frame_end <= r_s1_ctl.frame_end;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// ===== src/lgmf_checker.sv =====
`timescale 1ns / 1ps

`include "label_grid_majority_filter_top_macros.svh"

module lgmf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_stall,
    input logic           i_out_valid,
    input logic           i_out_stall,
    input lgmf_pkg::t_out i_out_data
);

    // A stalled result stays offered and unchanged.
    `LGMF_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data), "stalled result item changed or vanished")

    // Every result names a real class.
    `LGMF_ASSERT(a_class_range, i_clk, i_rst_n, i_out_valid |-> (4'(i_out_data.smoothed) < 4'(lgmf_pkg::NUM_CLASSES)), "result class out of range")

    // The input side only waits when a result is held up on the output side.
    `LGMF_ASSERT(a_stall_cause, i_clk, i_rst_n, i_in_stall |-> i_out_valid && i_out_stall, "input stalled without a blocked result item")

    // Reset empties the output register.
    `LGMF_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !i_out_valid, "result item offered straight after reset")

endmodule

bind label_grid_majority_filter_top lgmf_checker u_lgmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_stall),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_data  (o_data)
);

// ===== test/tb_label_grid_majority_filter_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the 3x3 majority filter. An initial block builds
// frames of cells and drain items and hands them to a clocked driver through
// a queue. A clocked monitor samples both channels at the rising edge: every
// accepted input item is run through a local copy of the filter, whose
// expected results wait in a queue, and every accepted result is checked
// against the oldest of them. All inputs change on the falling edge, so
// nothing depends on the order of events inside a time step.
module tb_label_grid_majority_filter_top;

    localparam int unsigned MAX_COLS     = 1024;
    localparam int unsigned MAX_ROW      = 65535;
    localparam int unsigned MAX_GAP      = 16;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned QUIET_LIMIT  = 5000;
    localparam int unsigned SETTLE_PAD   = 8;
    localparam int unsigned RANDOM_ITEMS = 1780;

    // Ways in which a frame may be closed off in the random part.
    typedef enum int {
        FRAME_WHOLE,
        FRAME_SHORT_DRAIN,
        FRAME_NOISY_TAIL
    } t_frame_shape;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_stall;
    lgmf_pkg::t_in  i_data  = '0;
    logic           o_valid;
    logic           i_stall = 1'b0;
    lgmf_pkg::t_out o_data;
    logic           psel    = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite  = 1'b0;
    logic [2:0]     paddr   = '0;
    logic [31:0]    pwdata  = '0;
    logic [31:0]    prdata;
    logic           pready;

    label_grid_majority_filter_top #(
        .MAX_COLS (MAX_COLS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the filter: registers, line stores, window and the
    // input and output position counters. Entries never written read as
    // zero here; the stimulus never lets such an entry reach a result.
    logic [lgmf_pkg::COL_W-1:0]   cols_reg = 11'd64;
    logic [lgmf_pkg::ROW_W-1:0]   rows_reg = 16'd64;
    logic [lgmf_pkg::LABEL_W-1:0] above_line [MAX_COLS] = '{default: '0};
    logic [lgmf_pkg::LABEL_W-1:0] cur_line   [MAX_COLS] = '{default: '0};
    logic [lgmf_pkg::LABEL_W-1:0] win        [9]        = '{default: '0};
    int unsigned        in_c  = 0;
    int unsigned        in_r  = 0;
    int unsigned        out_c = 0;
    int unsigned        out_r = 0;

    lgmf_pkg::t_out smooth_q   [$];
    lgmf_pkg::t_in  pend_items [$];

    // Accept flags written at the rising edge and read at the falling edge, then driver and receiver state.
    bit             in_acc   = 1'b0;
    bit             out_acc  = 1'b0;
    bit             drv_busy = 1'b0;
    bit             idle_on  = 1'b1;
    bit             hold_req = 1'b0;
    lgmf_pkg::t_in  drv_item = '0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned hold_left = 0;
    int unsigned quiet    = 0;
    int unsigned fails    = 0;
    int unsigned cells_queued = 0;

    // The clock runs with a 20 ns period from time zero.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_cols();
        if (cols_reg == 0) return 1;
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return 32'(cols_reg);
    endfunction

    function automatic int unsigned eff_rows();
        return (rows_reg == 0) ? 1 : 32'(rows_reg);
    endfunction

    // Takes one accepted item through the filter and queues the smoothed
    // cell it releases, if any. The window shifts left by one column; the
    // newest column holds the cell two rows up, one row up and the new one.
    function automatic void smooth_cell(input lgmf_pkg::t_in it);
        int unsigned                  nc, nr, c, best, best_n, k, dc, dr;
        int unsigned                  tally [lgmf_pkg::NUM_CLASSES];
        logic [lgmf_pkg::LABEL_W-1:0] lab, top, mid, cls;
        logic                         emit, last;
        lgmf_pkg::t_out               res;
        nc  = eff_cols();
        nr  = eff_rows();
        lab = it.flush ? '0 : it.label;
        c   = (in_c < MAX_COLS) ? in_c : 0;
        top = above_line[c];
        mid = cur_line[c];
        above_line[c] = mid;
        cur_line[c]   = lab;
        for (k = 0; k < 6; k++) begin
            win[k] = win[k + 3];
        end
        win[6] = top;
        win[7] = mid;
        win[8] = lab;

        emit = (in_r >= 2) || (in_r == 1 && in_c >= 1);
        if (in_c + 1 >= nc) begin
            in_c = 0;
            if (in_r < MAX_ROW) in_r++;
        end else begin
            in_c++;
        end
        if (!emit) return;

        // Count the classes of the neighbours that lie inside the grid.
        for (k = 0; k < lgmf_pkg::NUM_CLASSES; k++) begin
            tally[k] = 0;
        end
        for (dc = 0; dc < 3; dc++) begin
            if (dc == 0 && out_c < 1) continue;
            if (dc == 2 && out_c + 1 >= nc) continue;
            for (dr = 0; dr < 3; dr++) begin
                if (dr == 0 && out_r < 1) continue;
                if (dr == 2 && out_r + 1 >= nr) continue;
                cls = win[dc * 3 + dr];
                if (cls >= lgmf_pkg::NUM_CLASSES) cls = lgmf_pkg::FALLBACK_CLASS;
                tally[cls]++;
            end
        end
        // Strictly greater keeps the lowest class on a tie.
        best   = 0;
        best_n = 0;
        for (k = 0; k < lgmf_pkg::NUM_CLASSES; k++) begin
            if (tally[k] > best_n) begin
                best_n = tally[k];
                best   = k;
            end
        end

        last          = (out_r + 1 >= nr) && (out_c + 1 >= nc);
        res.smoothed  = best[lgmf_pkg::LABEL_W-1:0];
        res.frame_end = last;
        smooth_q.push_back(res);

        // The last cell of a frame rewinds every position counter.
        if (last) begin
            in_c  = 0;
            in_r  = 0;
            out_c = 0;
            out_r = 0;
        end else if (out_c + 1 >= nc) begin
            out_c = 0;
            if (out_r < MAX_ROW) out_r++;
        end else begin
            out_c++;
        end
    endfunction

    // Monitor: both channels are sampled here, results are checked before
    // the new item is predicted, and a watchdog counts cycles in which
    // neither channel moves an item.
    always @(posedge i_clk) begin
        lgmf_pkg::t_out want;
        in_acc  = i_rst_n && i_valid && !o_stall;
        out_acc = i_rst_n && o_valid && !i_stall;
        if (out_acc) begin
            if (smooth_q.size() == 0) begin
                $error("unexpected result: smoothed %0d frame_end %0b",
                       o_data.smoothed, o_data.frame_end);
                fails++;
            end else begin
                want = smooth_q.pop_front();
                if (o_data.smoothed !== want.smoothed) begin
                    $error("smoothed: expected %0d, actual %0d",
                           want.smoothed, o_data.smoothed);
                    fails++;
                end
                if (o_data.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, actual %0b",
                           want.frame_end, o_data.frame_end);
                    fails++;
                end
            end
        end
        if (in_acc) smooth_cell(i_data);

        if (!i_rst_n || in_acc || out_acc) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Driver: after each accepted item it waits a random number of cycles, while
    // idle_on is set, before offering the next one. A gap of zero keeps valid high without
    // a break, so the signal gets a single assignment per falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (drv_busy && in_acc) begin
                drv_busy = 1'b0;
                send_gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (!drv_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pend_items.size() != 0) begin
                    drv_item = pend_items.pop_front();
                    drv_busy = 1'b1;
                end
            end
            i_valid <= drv_busy;
            i_data  <= drv_item;
        end
    end

    // Receiver: stalls for a random number of cycles after each result while idle_on is set. A
    // request from the stimulus turns into one long hold-off, counted here,
    // during which the block has to fill up and stall its input.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_acc) recv_gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic void push_cell(input int unsigned lab, input logic fl);
        lgmf_pkg::t_in it;
        it.label = lgmf_pkg::LABEL_W'(lab);
        it.flush = fl;
        pend_items.push_back(it);
        cells_queued++;
    endfunction

    // Waits until the driver has handed over every queued item.
    task automatic settle_input();
        while (pend_items.size() != 0 || drv_busy) @(negedge i_clk);
    endtask

    // Waits until every expected result has come, then gives the block time
    // to finish whatever an item without a result started.
    task automatic wait_idle();
        while (pend_items.size() != 0 || drv_busy || smooth_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_PAD) @(negedge i_clk);
    endtask

    // Setup cycle, access cycle, then the bus returns to rest. The
    // register is written at the rising edge inside the access cycle.
    task automatic apb_write(input lgmf_pkg::t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lgmf_pkg::REG_COLS: cols_reg = val[lgmf_pkg::COL_W-1:0];
            lgmf_pkg::REG_ROWS: rows_reg = val[lgmf_pkg::ROW_W-1:0];
            default: ;
        endcase
    endtask

    // New grid size. A frame left open by a short drain is first closed
    // with flush items, so the block is always reprogrammed at a frame
    // boundary and every line store entry that is read has been written.
    task automatic configure(input int unsigned c, input int unsigned r);
        settle_input();
        while (!(in_c == 0 && in_r == 0 && out_c == 0 && out_r == 0)) begin
            push_cell($urandom_range(0, 7), 1'b1);
            settle_input();
        end
        wait_idle();
        apb_write(lgmf_pkg::REG_COLS, c);
        apb_write(lgmf_pkg::REG_ROWS, r);
    endtask

    // One frame of cells at the current size, followed by its drain items.
    // Cells often repeat their left neighbour so that regions form and the
    // majority has something to decide; a few are flush items or codes out
    // of the class range. Some drain items are ordinary cells.
    task automatic queue_frame(input t_frame_shape shape);
        int unsigned nc, nr, n, drain, pick, prev;
        nc   = eff_cols();
        nr   = eff_rows();
        prev = $urandom_range(0, lgmf_pkg::NUM_CLASSES - 1);
        for (n = 0; n < nc * nr; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                push_cell($urandom_range(0, 7), 1'b1);
                continue;
            end
            if (pick < 8)        prev = $urandom_range(lgmf_pkg::NUM_CLASSES, 7);
            else if (pick >= 50) prev = $urandom_range(0, lgmf_pkg::NUM_CLASSES - 1);
            push_cell(prev, 1'b0);
        end
        case (shape)
            FRAME_SHORT_DRAIN: drain = $urandom_range(0, nc);
            FRAME_NOISY_TAIL:  drain = nc + 1 + $urandom_range(1, 2 * nc);
            default:           drain = nc + 1;
        endcase
        for (n = 0; n < drain; n++) begin
            push_cell($urandom_range(0, 7), $urandom_range(0, 9) != 0);
        end
    endtask

    initial begin
        int unsigned  start, pick, nc, nr;
        t_frame_shape shape;

        // Reset is held from time zero and released once, on a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames. A 3 x 2 grid with the top class codes, the two
        // out-of-range codes, a flush item inside the frame, and a plain
        // cell among the drain items.
        configure(3, 2);
        push_cell(7, 1'b0); push_cell(6, 1'b0); push_cell(5, 1'b0);
        push_cell(0, 1'b0); push_cell(3, 1'b1); push_cell(4, 1'b0);
        push_cell(0, 1'b1); push_cell(7, 1'b1); push_cell(2, 1'b0);
        push_cell(5, 1'b1);
        // Zero in both registers counts as a single cell.
        configure(0, 0);
        push_cell(3, 1'b0); push_cell(6, 1'b1); push_cell(1, 1'b0);
        // A narrow column where ties and clear majorities alternate.
        configure(2, 3);
        push_cell(2, 1'b0); push_cell(2, 1'b0); push_cell(5, 1'b0);
        push_cell(2, 1'b0); push_cell(5, 1'b0); push_cell(5, 1'b0);
        push_cell(0, 1'b1); push_cell(0, 1'b1); push_cell(0, 1'b1);

        // Random part. The first frame runs into a long hold-off at the
        // receiver while the driver keeps offering items without gaps.
        configure(8, 6);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        queue_frame(FRAME_WHOLE);
        settle_input();

        start = cells_queued;
        while (cells_queued - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                nc = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
                nr = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
                configure(nc, nr);
            end
            idle_on = ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 99);
            if (pick < 85)      shape = FRAME_WHOLE;
            else if (pick < 95) shape = FRAME_SHORT_DRAIN;
            else                shape = FRAME_NOISY_TAIL;
            queue_frame(shape);
            while (pend_items.size() != 0) @(negedge i_clk);
        end

        wait_idle();
        if (fails == 0 && smooth_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== label_grid_majority_filter_top.f =====
+incdir+src
src/lgmf_pkg.sv
src/lgmf_line_mem.sv
src/lgmf_pos.sv
src/lgmf_vote.sv
src/label_grid_majority_filter_top.sv
src/lgmf_checker.sv
test/tb_label_grid_majority_filter_top.sv
